/* hw/rtl/brq_pkg.sv */
// Shared types, codes and constants of the backoff retry queue.
// Depends on nothing; brq_ctrl and the top level import it.
`default_nettype none

package brq_pkg;

  localparam int unsigned QueueDepthDefault = 128;
  localparam int unsigned HandleBitsDefault = 16;

  localparam int unsigned TriesW   = 8;
  localparam int unsigned BackoffW = 17;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned DueW     = 31;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [BackoffW-1:0] InitBackoff    = BackoffW'(5000);
  localparam logic [BackoffW-1:0] MaxBackoff     = BackoffW'(120000);
  localparam logic [BackoffW-1:0] HalfMaxBackoff = BackoffW'(120000 / 2);
  localparam logic [TimeW-1:0]    OfflineDefer   = TimeW'(3000);

  typedef enum logic [1:0] {
    FUNC_ENQUEUE = 2'd0,
    FUNC_TICK    = 2'd1,
    FUNC_CLEAR   = 2'd2,
    FUNC_QUERY   = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    STAT_QUEUED  = 4'd0,
    STAT_FULL    = 4'd1,
    STAT_EMPTY   = 4'd2,
    STAT_NOT_DUE = 4'd3,
    STAT_DEFER   = 4'd4,
    STAT_SENT    = 4'd5,
    STAT_RETRY   = 4'd6,
    STAT_GAVE_UP = 4'd7,
    STAT_CLEARED = 4'd8
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_RETRIES       = 1'b0,
    CFG_DELETE_ON_SUCCESS = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_DUE  = 2'd2
  } state_e;

  typedef struct packed {
    logic [TriesW-1:0] max_retries;
    logic              delete_on_success;
  } cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/brq_job_mem.sv */
// Job store of the retry queue: one write port and one registered read port.
// Depends on nothing outside this file.
`default_nettype none

module brq_job_mem #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 89
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/brq_ctrl.sv */
// Sequencer of the retry queue: head read, update, write back and result register.
// Depends on brq_pkg; drives the job store brq_job_mem.
`default_nettype none

module brq_ctrl
  import brq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault,
  parameter int unsigned HANDLE_BITS = HandleBitsDefault
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire cfg_t                                cfg_i,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [1:0]                          func_i,
  input  wire logic [HANDLE_BITS-1:0]              source_handle_i,
  input  wire logic [HANDLE_BITS-1:0]              dest_handle_i,
  input  wire logic [TimeW-1:0]                    now_ms_i,
  input  wire logic                                network_ok_i,
  input  wire logic                                upload_ok_i,
  output logic                                     mem_we_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0]           mem_waddr_o,
  output logic [2*HANDLE_BITS+TriesW+BackoffW+TimeW-1:0] mem_wdata_o,
  output logic                                     mem_re_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0]           mem_raddr_o,
  input  wire logic [2*HANDLE_BITS+TriesW+BackoffW+TimeW-1:0] mem_rdata_i,
  output logic                                     result_valid_o,
  output logic [3:0]                               status_o,
  output logic [HANDLE_BITS-1:0]                   attempt_source_o,
  output logic [HANDLE_BITS-1:0]                   attempt_dest_o,
  output logic                                     delete_source_o,
  output logic [TriesW-1:0]                        tries_done_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]         entry_count_o,
  output logic [DueW-1:0]                          next_due_ms_o
);

  localparam int unsigned IdxW       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SumW       = IdxW + 2;
  localparam int unsigned DueLsb     = 0;
  localparam int unsigned BackoffLsb = TimeW;
  localparam int unsigned TriesLsb   = BackoffLsb + BackoffW;
  localparam int unsigned DstLsb     = TriesLsb + TriesW;
  localparam int unsigned SrcLsb     = DstLsb + HANDLE_BITS;

  // Positive signed distance to the due time, zero when due or overdue.
  function automatic logic [DueW-1:0] wait_ms(input logic [TimeW-1:0] due,
                                              input logic [TimeW-1:0] now);
    logic [TimeW-1:0] diff;
    diff = due - now;
    if ((diff != '0) && !diff[TimeW-1]) begin
      return diff[DueW-1:0];
    end
    return '0;
  endfunction

  state_e                 state_q, state_d;
  logic [IdxW-1:0]        head_q, head_d;
  logic [CntW-1:0]        count_q, count_d;
  logic                   reload;

  func_e                  func_q;
  logic [HANDLE_BITS-1:0] src_q, dst_q;
  logic [TimeW-1:0]       now_q;
  logic                   net_q, upl_q;

  logic                   res_valid_q, res_valid_d;
  status_e                res_status_q, res_status_d;
  logic [HANDLE_BITS-1:0] res_src_q, res_src_d;
  logic [HANDLE_BITS-1:0] res_dst_q, res_dst_d;
  logic                   res_del_q, res_del_d;
  logic [TriesW-1:0]      res_tries_q, res_tries_d;
  logic [CntW-1:0]        res_count_q, res_count_d;
  logic [DueW-1:0]        res_due_q, res_due_d;

  logic                   accept;
  logic [HANDLE_BITS-1:0] e_src, e_dst;
  logic [TriesW-1:0]      e_tries, new_tries;
  logic [BackoffW-1:0]    e_backoff, new_backoff;
  logic [TimeW-1:0]       e_due;
  logic [DueW-1:0]        head_wait;
  logic [IdxW-1:0]        head_next, tail;
  logic [SumW-1:0]        tail_sum;
  logic                   pop;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  assign e_src     = mem_rdata_i[SrcLsb +: HANDLE_BITS];
  assign e_dst     = mem_rdata_i[DstLsb +: HANDLE_BITS];
  assign e_tries   = mem_rdata_i[TriesLsb +: TriesW];
  assign e_backoff = mem_rdata_i[BackoffLsb +: BackoffW];
  assign e_due     = mem_rdata_i[DueLsb +: TimeW];
  assign head_wait = wait_ms(e_due, now_q);

  assign new_tries   = e_tries + TriesW'(1);
  assign new_backoff = (e_backoff >= HalfMaxBackoff) ? MaxBackoff
                                                     : {e_backoff[BackoffW-2:0], 1'b0};

  assign head_next = (head_q == IdxW'(QUEUE_DEPTH - 1)) ? '0 : head_q + IdxW'(1);
  assign tail_sum  = SumW'(head_q) + SumW'(count_q);
  assign tail      = (tail_sum >= SumW'(QUEUE_DEPTH)) ? IdxW'(tail_sum - SumW'(QUEUE_DEPTH))
                                                      : tail_sum[IdxW-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = reload ? ST_DUE : ST_IDLE;
      end
      ST_DUE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath and memory accesses.
  always_comb begin
    head_d       = head_q;
    count_d      = count_q;
    reload       = 1'b0;
    pop          = 1'b0;
    mem_we_o     = 1'b0;
    mem_waddr_o  = head_q;
    mem_wdata_o  = mem_rdata_i;
    mem_re_o     = 1'b0;
    mem_raddr_o  = head_q;
    res_valid_d  = 1'b0;
    res_status_d = res_status_q;
    res_src_d    = res_src_q;
    res_dst_d    = res_dst_q;
    res_del_d    = res_del_q;
    res_tries_d  = res_tries_q;
    res_count_d  = res_count_q;
    res_due_d    = res_due_q;

    unique case (state_q)
      ST_IDLE: begin
        mem_re_o = accept;
      end
      ST_EXEC: begin
        res_valid_d  = 1'b1;
        res_src_d    = '0;
        res_dst_d    = '0;
        res_del_d    = 1'b0;
        res_tries_d  = '0;
        res_due_d    = '0;
        res_status_d = STAT_EMPTY;
        unique case (func_q)
          FUNC_ENQUEUE: begin
            if (count_q == CntW'(QUEUE_DEPTH)) begin
              res_status_d = STAT_FULL;
              res_due_d    = head_wait;
            end else begin
              mem_we_o     = 1'b1;
              mem_waddr_o  = tail;
              mem_wdata_o  = {src_q, dst_q, TriesW'(0), InitBackoff, now_q};
              count_d      = count_q + CntW'(1);
              res_status_d = STAT_QUEUED;
              res_due_d    = (count_q == '0) ? '0 : head_wait;
            end
          end
          FUNC_CLEAR: begin
            head_d       = '0;
            count_d      = '0;
            res_status_d = STAT_CLEARED;
          end
          FUNC_QUERY: begin
            if (count_q != '0) begin
              res_status_d = STAT_NOT_DUE;
              res_due_d    = head_wait;
            end
          end
          FUNC_TICK: begin
            if (count_q == '0) begin
              res_status_d = STAT_EMPTY;
            end else if (head_wait != '0) begin
              res_status_d = STAT_NOT_DUE;
              res_due_d    = head_wait;
            end else if (!net_q) begin
              mem_we_o     = 1'b1;
              mem_wdata_o  = {e_src, e_dst, e_tries, e_backoff, now_q + OfflineDefer};
              res_status_d = STAT_DEFER;
              res_due_d    = DueW'(OfflineDefer);
            end else begin
              res_src_d = e_src;
              res_dst_d = e_dst;
              if (upl_q) begin
                res_tries_d  = e_tries;
                res_del_d    = cfg_i.delete_on_success;
                res_status_d = STAT_SENT;
                pop          = 1'b1;
              end else if (new_tries >= cfg_i.max_retries) begin
                res_tries_d  = new_tries;
                res_status_d = STAT_GAVE_UP;
                pop          = 1'b1;
              end else begin
                mem_we_o     = 1'b1;
                mem_wdata_o  = {e_src, e_dst, new_tries, new_backoff,
                                now_q + TimeW'(new_backoff)};
                res_tries_d  = new_tries;
                res_status_d = STAT_RETRY;
                res_due_d    = DueW'(new_backoff);
              end
            end
          end
          default: begin
            res_status_d = STAT_EMPTY;
          end
        endcase

        if (pop) begin
          head_d  = head_next;
          count_d = count_q - CntW'(1);
          if (count_q != CntW'(1)) begin
            // The new head's due time still has to come out of the store.
            reload      = 1'b1;
            res_valid_d = 1'b0;
            mem_re_o    = 1'b1;
            mem_raddr_o = head_next;
          end
        end
        res_count_d = count_d;
      end
      ST_DUE: begin
        res_due_d   = head_wait;
        res_valid_d = 1'b1;
      end
      default: begin
        res_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_e'(func_i);
      src_q  <= source_handle_i;
      dst_q  <= dest_handle_i;
      now_q  <= now_ms_i;
      net_q  <= network_ok_i;
      upl_q  <= upload_ok_i;
    end
    res_status_q <= res_status_d;
    res_src_q    <= res_src_d;
    res_dst_q    <= res_dst_d;
    res_del_q    <= res_del_d;
    res_tries_q  <= res_tries_d;
    res_count_q  <= res_count_d;
    res_due_q    <= res_due_d;
  end

  assign result_valid_o   = res_valid_q;
  assign status_o         = res_status_q;
  assign attempt_source_o = res_src_q;
  assign attempt_dest_o   = res_dst_q;
  assign delete_source_o  = res_del_q;
  assign tries_done_o     = res_tries_q;
  assign entry_count_o    = res_count_q;
  assign next_due_ms_o    = res_due_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("job count above queue depth");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we_o && mem_re_o && (mem_waddr_o == mem_raddr_o)))
    else $error("store read and written at the same entry in one cycle");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(state_q) == ST_EXEC) || ($past(state_q) == ST_DUE))
    else $error("result strobe without a finished request");

  a_reload_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUE) |-> (count_q != '0))
    else $error("head reload with an empty queue");

  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EXEC) && !result_valid_o)
    else $error("accepted request did not enter execution");

endmodule

`default_nettype wire

/* hw/rtl/backoff_retry_queue_top.sv */
// Top level of the backoff retry queue: configuration registers, sequencer and job store.
// Depends on brq_pkg, brq_ctrl and brq_job_mem.
`default_nettype none

// A FIFO of up to QUEUE_DEPTH transfer jobs with exponential backoff. A request
// (enqueue, tick, clear or query) is taken on a rising edge with start high and
// busy low. Every request yields exactly one result, shown for a single cycle with
// result_valid_o high; the receiver cannot hold it off, so it must capture the
// result in that cycle. Each request reads the head job from the job store, which
// has one write and one registered read port; a tick may then update and write it
// back. busy stays high until the result is registered, so a new request is not
// taken before the last one is done. A tick that sends or drops the head job while
// other jobs remain needs a second read of the store to fetch the new head's due
// time; such a request passes through the EXEC and DUE states before its result.
// The result of one request may be on the ports in the same cycle as the next
// request is taken. The job store is not cleared at reset; only live entries are ever
// used. Configuration (retry limit, delete-on-success) must be written by the user
// via the cfg_* port while no request is in progress; the block does not enforce it.

module backoff_retry_queue_top
  import brq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault,
  parameter int unsigned HANDLE_BITS = HandleBitsDefault
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]                  cfg_idx_i,
  input  wire logic [CfgDataW-1:0]                 cfg_wdata_i,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [1:0]                          func_i,
  input  wire logic [HANDLE_BITS-1:0]              source_handle_i,
  input  wire logic [HANDLE_BITS-1:0]              dest_handle_i,
  input  wire logic [TimeW-1:0]                    now_ms_i,
  input  wire logic                                network_ok_i,
  input  wire logic                                upload_ok_i,
  output logic                                     result_valid_o,
  output logic [3:0]                               status_o,
  output logic [HANDLE_BITS-1:0]                   attempt_source_o,
  output logic [HANDLE_BITS-1:0]                   attempt_dest_o,
  output logic                                     delete_source_o,
  output logic [TriesW-1:0]                        tries_done_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]         entry_count_o,
  output logic [DueW-1:0]                          next_due_ms_o
);

  localparam int unsigned IdxW   = $clog2(QUEUE_DEPTH);
  localparam int unsigned EntryW = 2 * HANDLE_BITS + TriesW + BackoffW + TimeW;

  // Configuration registers; reset to a retry limit of five and deletion enabled.
  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      if (cfg_idx_i == CFG_MAX_RETRIES) begin
        cfg_d.max_retries = cfg_wdata_i[TriesW-1:0];
      end else begin
        cfg_d.delete_on_success = cfg_wdata_i[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_retries       <= TriesW'(5);
      cfg_q.delete_on_success <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Memory port between the sequencer and the job store.
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  logic [EntryW-1:0] mem_wdata;
  logic              mem_re;
  logic [IdxW-1:0]   mem_raddr;
  logic [EntryW-1:0] mem_rdata;

  brq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .start            (start),
    .busy             (busy),
    .func_i           (func_i),
    .source_handle_i  (source_handle_i),
    .dest_handle_i    (dest_handle_i),
    .now_ms_i         (now_ms_i),
    .network_ok_i     (network_ok_i),
    .upload_ok_i      (upload_ok_i),
    .mem_we_o         (mem_we),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .mem_re_o         (mem_re),
    .mem_raddr_o      (mem_raddr),
    .mem_rdata_i      (mem_rdata),
    .result_valid_o   (result_valid_o),
    .status_o         (status_o),
    .attempt_source_o (attempt_source_o),
    .attempt_dest_o   (attempt_dest_o),
    .delete_source_o  (delete_source_o),
    .tries_done_o     (tries_done_o),
    .entry_count_o    (entry_count_o),
    .next_due_ms_o    (next_due_ms_o)
  );

  brq_job_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (EntryW)
  ) u_job_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire
